// ===== hw/rtl/sss_pkg.sv =====
// Shared types, constants and the microcode program of the small set sorter.
// Depends on nothing; sss_seq, sss_dp, the top level and the testbench import it.
`timescale 1ns / 1ps

package sss_pkg;

    localparam int DEF_MAX_ITEMS  = 16;
    localparam int DEF_VALUE_BITS = 8;

    localparam int STEP_BITS = 3;
    typedef logic [STEP_BITS-1:0] t_step;

    // Program steps. The drop step is the highest code, so falling through
    // from it wraps around to the wait step.
    localparam t_step ST_WAIT    = 3'd0;
    localparam t_step ST_FULLCHK = 3'd1;
    localparam t_step ST_SHIFT   = 3'd2;
    localparam t_step ST_PLACE   = 3'd3;
    localparam t_step ST_EMIT0   = 3'd4;
    localparam t_step ST_EMIT    = 3'd5;
    localparam t_step ST_DONE    = 3'd6;
    localparam t_step ST_DROP    = 3'd7;

    // Stall sources.
    localparam logic [1:0] STALL_NONE = 2'd0;
    localparam logic [1:0] STALL_IN   = 2'd1;
    localparam logic [1:0] STALL_OUT  = 2'd2;

    // Jump conditions.
    localparam logic [2:0] C_NONE   = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_FULL   = 3'd2;
    localparam logic [2:0] C_SHIFT  = 3'd3;
    localparam logic [2:0] C_NLAST  = 3'd4;
    localparam logic [2:0] C_MORE   = 3'd5;
    localparam logic [2:0] C_LAST   = 3'd6;

    // Pointer operations.
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_CNT  = 3'd1;
    localparam logic [2:0] PTR_DEC  = 3'd2;
    localparam logic [2:0] PTR_INC  = 3'd3;
    localparam logic [2:0] PTR_CLR  = 3'd4;

    // Store write operations.
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_KEY  = 2'd1;
    localparam logic [1:0] WR_DATA = 2'd2;

    // Element count operations.
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_CLR  = 2'd2;

    // Overflow flag operations.
    localparam logic [1:0] DROP_HOLD = 2'd0;
    localparam logic [1:0] DROP_SET  = 2'd1;
    localparam logic [1:0] DROP_CLR  = 2'd2;

    typedef struct packed {
        logic [1:0] stall;
        logic [2:0] cond;
        logic       gated;
        t_step      jump;
        logic [2:0] ptr_op;
        logic [1:0] wr_op;
        logic [1:0] cnt_op;
        logic [1:0] drop_op;
        logic       rd_emit;
        logic       take_in;
        logic       emit;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic full;
        logic shift;
        logic nlast;
        logic more;
    } t_sts;

    function automatic t_ctl mk(logic [1:0] stall, logic [2:0] cond, logic gated,
                                t_step jump, logic [2:0] ptr_op, logic [1:0] wr_op,
                                logic [1:0] cnt_op, logic [1:0] drop_op,
                                logic rd_emit, logic take_in, logic emit);
        t_ctl c;
        c.stall   = stall;
        c.cond    = cond;
        c.gated   = gated;
        c.jump    = jump;
        c.ptr_op  = ptr_op;
        c.wr_op   = wr_op;
        c.cnt_op  = cnt_op;
        c.drop_op = drop_op;
        c.rd_emit = rd_emit;
        c.take_in = take_in;
        c.emit    = emit;
        return c;
    endfunction

    // The program. Inserting keeps the store sorted: the hole walks down
    // while the entry below it is larger than the new key.
    function automatic t_ctl ucode_rom(t_step step);
        t_ctl c;
        c = mk(STALL_NONE, C_ALWAYS, 1'b0, ST_WAIT, PTR_HOLD, WR_NONE,
               CNT_HOLD, DROP_HOLD, 1'b0, 1'b0, 1'b0);
        unique case (step)
            ST_WAIT:    c = mk(STALL_IN, C_NONE, 1'b0, ST_WAIT, PTR_CNT, WR_NONE,
                               CNT_HOLD, DROP_HOLD, 1'b0, 1'b1, 1'b0);
            ST_FULLCHK: c = mk(STALL_NONE, C_FULL, 1'b0, ST_DROP, PTR_HOLD, WR_NONE,
                               CNT_HOLD, DROP_HOLD, 1'b0, 1'b0, 1'b0);
            ST_SHIFT:   c = mk(STALL_NONE, C_SHIFT, 1'b1, ST_SHIFT, PTR_DEC, WR_DATA,
                               CNT_HOLD, DROP_HOLD, 1'b0, 1'b0, 1'b0);
            ST_PLACE:   c = mk(STALL_NONE, C_NLAST, 1'b0, ST_WAIT, PTR_HOLD, WR_KEY,
                               CNT_INC, DROP_HOLD, 1'b0, 1'b0, 1'b0);
            ST_EMIT0:   c = mk(STALL_NONE, C_NONE, 1'b0, ST_EMIT, PTR_CLR, WR_NONE,
                               CNT_HOLD, DROP_HOLD, 1'b1, 1'b0, 1'b0);
            ST_EMIT:    c = mk(STALL_OUT, C_MORE, 1'b0, ST_EMIT, PTR_INC, WR_NONE,
                               CNT_HOLD, DROP_HOLD, 1'b1, 1'b0, 1'b1);
            ST_DONE:    c = mk(STALL_NONE, C_ALWAYS, 1'b0, ST_WAIT, PTR_HOLD, WR_NONE,
                               CNT_CLR, DROP_CLR, 1'b0, 1'b0, 1'b0);
            ST_DROP:    c = mk(STALL_NONE, C_LAST, 1'b0, ST_EMIT0, PTR_HOLD, WR_NONE,
                               CNT_HOLD, DROP_SET, 1'b0, 1'b0, 1'b0);
            default:    c = mk(STALL_NONE, C_ALWAYS, 1'b0, ST_WAIT, PTR_HOLD, WR_NONE,
                               CNT_HOLD, DROP_HOLD, 1'b0, 1'b0, 1'b0);
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/sss_if.sv =====
// Valid/ready channel interfaces for the input and result requests of the sorter.
// Depends on nothing.
`timescale 1ns / 1ps

interface sss_in_if #(
    parameter int VALUE_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sss_out_if #(
    parameter int VALUE_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  final_res;
    logic                  overflow;

    modport source (output valid, output sorted_value, output final_res,
                     output overflow, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                     input overflow, output ready);
endinterface

// ===== hw/rtl/sss_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sss_seq.sv =====
// Microcode sequencer: step counter, program table lookup, stall and jump logic.
// Depends on sss_pkg for the control word, status bundle and program.
`timescale 1ns / 1ps

module sss_seq
    import sss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_take_in
);

    t_step r_step;
    t_step n_step;
    t_ctl  raw;
    logic  stall;
    logic  cond_true;
    logic  fire;

    always_comb begin
        raw = ucode_rom(r_step);

        unique case (raw.stall)
            STALL_NONE: stall = 1'b0;
            STALL_IN:   stall = !i_sts.in_valid;
            STALL_OUT:  stall = i_sts.out_busy;
            default:    stall = 1'b0;
        endcase

        unique case (raw.cond)
            C_NONE:   cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_FULL:   cond_true = i_sts.full;
            C_SHIFT:  cond_true = i_sts.shift;
            C_NLAST:  cond_true = i_sts.nlast;
            C_MORE:   cond_true = i_sts.more;
            C_LAST:   cond_true = !i_sts.nlast;
            default:  cond_true = 1'b0;
        endcase

        fire = !stall && (!raw.gated || cond_true);

        // Falling through from the highest step wraps to the wait step.
        if (stall) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = raw.jump;
        end else begin
            n_step = r_step + 1'b1;
        end

        // Operations take effect only on a step that is not held and, on a gated step, only when its condition is true.
        o_ctl = raw;
        if (!fire) begin
            o_ctl.ptr_op  = PTR_HOLD;
            o_ctl.wr_op   = WR_NONE;
            o_ctl.cnt_op  = CNT_HOLD;
            o_ctl.drop_op = DROP_HOLD;
            o_ctl.take_in = 1'b0;
            o_ctl.emit    = 1'b0;
        end
    end

    assign o_take_in = raw.take_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== hw/rtl/sss_dp.sv =====
// Sorter datapath: element store, count, hole pointer, key and result register.
// Depends on sss_pkg, the channel interfaces and sss_ram.
`timescale 1ns / 1ps

module sss_dp
    import sss_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sss_in_if.sink    i_in,
    sss_out_if.source o_out,
    input  t_ctl      i_ctl,
    input  logic      i_take_in,
    output t_sts      o_sts
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0]         r_cnt;
    logic [AW-1:0]         r_ptr;
    logic [AW-1:0]         n_ptr;
    logic [VALUE_BITS-1:0] r_key;
    logic                  r_last;
    logic                  r_drop;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_final;
    logic                  r_out_ovf;

    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] rdata;
    logic                  we;
    logic [VALUE_BITS-1:0] wdata;
    logic                  more;

    always_comb begin
        case (i_ctl.ptr_op)
            PTR_CNT: n_ptr = r_cnt[AW-1:0];
            PTR_DEC: n_ptr = r_ptr - 1'b1;
            PTR_INC: n_ptr = r_ptr + 1'b1;
            PTR_CLR: n_ptr = '0;
            default: n_ptr = r_ptr;
        endcase
    end

    // While inserting, the entry just below the hole is prefetched.
    assign rd_addr = i_ctl.rd_emit ? n_ptr : n_ptr - 1'b1;
    assign we      = (i_ctl.wr_op != WR_NONE);
    assign wdata   = (i_ctl.wr_op == WR_KEY) ? r_key : rdata;
    assign more    = ((CW'(r_ptr) + 1'b1) != r_cnt);

    sss_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ptr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_ctl.take_in) begin
            r_key  <= i_in.value;
            r_last <= i_in.last;
        end
        if (i_ctl.emit) begin
            r_out_value <= rdata;
            r_out_final <= !more;
            r_out_ovf   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctl.cnt_op)
                CNT_INC: r_cnt <= r_cnt + 1'b1;
                CNT_CLR: r_cnt <= '0;
                default: r_cnt <= r_cnt;
            endcase
            case (i_ctl.drop_op)
                DROP_SET: r_drop <= 1'b1;
                DROP_CLR: r_drop <= 1'b0;
                default:  r_drop <= r_drop;
            endcase
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready         = i_take_in;
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.final_res    = r_out_final;
    assign o_out.overflow     = r_out_ovf;

    assign o_sts.in_valid = i_in.valid;
    assign o_sts.out_busy = r_out_valid && !o_out.ready;
    assign o_sts.full     = (r_cnt == CW'(MAX_ITEMS));
    assign o_sts.shift    = (r_ptr != '0) && (rdata > r_key);
    assign o_sts.nlast    = !r_last;
    assign o_sts.more     = more;

endmodule

// ===== hw/rtl/small_set_sorter_top.sv =====
// Small set sorter top level: microcode sequencer plus sorting datapath.
// Depends on sss_pkg, sss_if, sss_seq, sss_dp and sss_ram.
//
// Usage: values arrive one per request on i_in, with last set on the final
// value of a set. Each value is inserted into a store that is kept sorted:
// after the wait and full check steps, the shift step moves each stored value
// larger than it up one entry, one entry per cycle through the single write
// port of the store, and the place step writes the new value. No new value is
// taken until the current one is placed or dropped. A value that arrives
// while the store holds MAX_ITEMS entries is dropped and the overflow flag is
// set on all results of that set. After the last value, results leave on
// o_out in ascending order, one per cycle while the receiver takes them; the
// first result is registered by the emit step, after the EMIT0 step starts
// the first read, and final_res marks the last one. When the receiver stalls,
// the result register holds its request and the sequencer waits on the emit
// step. After the final result is registered, the done step clears the set,
// then the block takes new values again, even while that result still waits.
// Reset (synchronous, active low) empties the set, clears the overflow flag
// and drops any pending result; the store needs no clearing.
`timescale 1ns / 1ps

module small_set_sorter_top
    import sss_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sss_in_if.sink    i_in,
    sss_out_if.source o_out
);

    t_ctl ctl;
    t_sts sts;
    logic take_in;

    // The sequencer walks the program; the datapath reports status back.
    sss_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .o_take_in (take_in)
    );

    sss_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_ctl     (ctl),
        .i_take_in (take_in),
        .o_sts     (sts)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for small_set_sorter_top: sends sets of values, predicts their sorted order
// and checks every result request field by field. Depends on sss_pkg, sss_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import sss_pkg::*;

    localparam int SET_CAPACITY = DEF_MAX_ITEMS;
    localparam int VALUE_W      = DEF_VALUE_BITS;
    localparam int COUNT_W      = $clog2(SET_CAPACITY + 1);

    // The receiver holds off long enough that a whole set is stored and its
    // emission stalls, so the block has to push back on its input as well.
    localparam int RX_HOLD_CYCLES = 300;
    // The end wait covers the longest insertion with margin.
    localparam int END_SETTLE     = 3 * (4 + SET_CAPACITY);
    localparam longint TIMEOUT_NS = 4_000_000;

    // One result request as the block should emit it.
    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               final_res;
        logic               overflow;
    } t_sorted_entry;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sss_in_if  #(.VALUE_BITS(VALUE_W)) in_ch ();
    sss_out_if #(.VALUE_BITS(VALUE_W)) out_ch ();

    small_set_sorter_top #(
        .MAX_ITEMS (SET_CAPACITY),
        .VALUE_BITS(VALUE_W)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the set being collected and the results it will produce.
    logic [VALUE_W-1:0] set_values [SET_CAPACITY];
    logic [COUNT_W-1:0] set_count      = '0;
    logic               set_overflowed = 1'b0;
    t_sorted_entry      expected_sorted_q [$];

    int  items_sent     = 0;
    int  mismatch_count = 0;
    // Random idling on either side; cleared for stretches and for the tail of the run.
    bit  tx_gaps_on      = 1'b0;
    bit  rx_gaps_on      = 1'b0;
    bit  rx_hold_pending = 1'b0;

    // Store an accepted value the way the block does. A value that finds the
    // store full is dropped and marks the set; a last value ends the set even
    // when it is dropped. At the end of a set, the stored values are sorted in
    // ascending order and queued as the expected results.
    task automatic predict_sorted_output(input logic [VALUE_W-1:0] v, input logic is_last);
        logic [VALUE_W-1:0] ordered [SET_CAPACITY];
        logic [VALUE_W-1:0] key;
        t_sorted_entry      r;
        int                 a;
        int                 b;
        int                 n;
        if (set_count < SET_CAPACITY) begin
            set_values[set_count] = v;
            set_count++;
        end else begin
            set_overflowed = 1'b1;
        end
        if (is_last) begin
            n = set_count;
            for (a = 0; a < n; a++) begin
                ordered[a] = set_values[a];
            end
            for (a = 1; a < n; a++) begin
                key = ordered[a];
                b = a;
                while (b > 0 && ordered[b - 1] > key) begin
                    ordered[b] = ordered[b - 1];
                    b--;
                end
                ordered[b] = key;
            end
            for (a = 0; a < n; a++) begin
                r.sorted_value = ordered[a];
                r.final_res    = (a == n - 1);
                r.overflow     = set_overflowed;
                expected_sorted_q = {expected_sorted_q, r};
            end
            set_count      = '0;
            set_overflowed = 1'b0;
        end
    endtask

    // Offer one value and wait for its handshake. Called at a rising edge;
    // returns at the edge where the request was accepted, so the caller may
    // drive the next request or an idle cycle without a second assignment.
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic is_last);
        int gap;
        if (tx_gaps_on && $urandom_range(4, 0) == 0) begin
            gap = $urandom_range(7, 1);
            in_ch.valid <= 1'b0;
            in_ch.value <= VALUE_W'($urandom);
            in_ch.last  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= is_last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        predict_sorted_output(v, is_last);
    endtask

    task automatic send_set(input int size, input int lo, input int hi);
        int i;
        for (i = 0; i < size; i++) begin
            send_value(VALUE_W'($urandom_range(hi, lo)), i == size - 1);
        end
    endtask

    // The sender stops offering until every queued result has come back.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (expected_sorted_q.size() != 0) @(posedge i_clk);
    endtask

    // Sets of one element, at both ends of the value range.
    task automatic test_single_value();
        send_value('0, 1'b1);
        send_value('1, 1'b1);
    endtask

    // Extremes, duplicates and alternating bit patterns in one set.
    task automatic test_extreme_values();
        send_value(8'd255, 1'b0);
        send_value(8'd0,   1'b0);
        send_value(8'd255, 1'b0);
        send_value(8'd128, 1'b0);
        send_value(8'd1,   1'b0);
        send_value(8'd170, 1'b0);
        send_value(8'd85,  1'b1);
    endtask

    // One value more than the store holds; the dropped value carries the last
    // flag, so the set must still end and every result must flag the overflow.
    task automatic test_store_overflow();
        int i;
        for (i = 0; i <= SET_CAPACITY; i++) begin
            send_value(VALUE_W'((i * 37 + 200) % 256), i == SET_CAPACITY);
        end
    endtask

    // Whole sets with random content. Most are short; some fill the store
    // exactly and some go past it. Idling on each side is switched per set.
    task automatic test_random_sets(input int item_target);
        int pick;
        int size;
        int lo;
        int hi;
        while (items_sent < item_target) begin
            tx_gaps_on = ($urandom_range(3, 0) != 0);
            rx_gaps_on = ($urandom_range(3, 0) != 0);
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                size = $urandom_range(5, 1);
            end else if (pick < 80) begin
                size = $urandom_range(SET_CAPACITY - 1, 6);
            end else if (pick < 90) begin
                size = SET_CAPACITY;
            end else begin
                size = $urandom_range(SET_CAPACITY + 6, SET_CAPACITY + 1);
            end
            pick = $urandom_range(3, 0);
            if (pick == 0) begin
                lo = 0;
                hi = 3;
            end else if (pick == 1) begin
                lo = 250;
                hi = 255;
            end else begin
                lo = 0;
                hi = 255;
            end
            send_set(size, lo, hi);
        end
    endtask

    // The receiver stops for a long stretch while sets keep coming, so the
    // emission stalls and the block has to hold off its input.
    task automatic test_receiver_hold();
        tx_gaps_on      = 1'b0;
        rx_hold_pending = 1'b1;
        send_set(10, 0, 255);
        send_set(10, 0, 255);
        send_set(10, 0, 255);
    endtask

    // Final stretch with no idling on either side.
    task automatic test_tail_no_idle(input int item_target);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        while (items_sent < item_target) begin
            send_set($urandom_range(8, 1), 0, 255);
        end
    endtask

    // Result receiver: random stall bursts, or one long hold when a test asks
    // for it. Exactly one assignment to ready per loop pass, then at least one edge.
    initial begin : result_receiver
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_pending) begin
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_pending = 1'b0;
            end else if (rx_gaps_on && $urandom_range(3, 0) == 0) begin
                gap = $urandom_range(7, 1);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Every accepted result is matched against the oldest expectation.
    t_sorted_entry want;
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_sorted_q.size() == 0) begin
                $display("%0t: unexpected result, value %0d final %0b overflow %0b",
                         $time, out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
                mismatch_count++;
            end else begin
                want = expected_sorted_q.pop_front();
                if (out_ch.sorted_value !== want.sorted_value) begin
                    $display("%0t: sorted_value expected %0d, actual %0d",
                             $time, want.sorted_value, out_ch.sorted_value);
                    mismatch_count++;
                end
                if (out_ch.final_res !== want.final_res) begin
                    $display("%0t: final_res expected %0b, actual %0b",
                             $time, want.final_res, out_ch.final_res);
                    mismatch_count++;
                end
                if (out_ch.overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0b, actual %0b",
                             $time, want.overflow, out_ch.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_value();
        test_extreme_values();
        test_store_overflow();
        wait_for_results();

        test_random_sets(120);
        test_receiver_hold();
        wait_for_results();
        test_random_sets(185);
        test_tail_no_idle(210);

        // Drain, then give the block time to show any stray result.
        wait_for_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_sorted_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
